### design/rtb_pkg.sv
// ---------------------------------------------------------------------------
// rtb_pkg: shared types and constants for the region threshold binarizer
// Configuration register indexes, decision mode codes, output levels and the
// configuration bundle passed from the register file to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

    // field widths fixed by the interface
    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned INDEX_W = 3;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_INVERT     = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_LOW_LEVEL  = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_HIGH_LEVEL = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_ROI_LEFT   = 3'd4;
    localparam logic [INDEX_W-1:0] CFG_ROI_RIGHT  = 3'd5;
    localparam logic [INDEX_W-1:0] CFG_ROI_TOP    = 3'd6;
    localparam logic [INDEX_W-1:0] CFG_ROI_BOTTOM = 3'd7;

    // decision modes
    localparam logic [MODE_W-1:0] MODE_BELOW      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ABOVE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUTSIDE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PROF_BELOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PROF_ABOVE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PROF_OUT   = 3'd5;

    // input commands
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    // output levels
    localparam logic [PIX_W-1:0] LEVEL_TARGET     = 8'd255;
    localparam logic [PIX_W-1:0] LEVEL_BACKGROUND = 8'd0;

    // register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'd4095;
    localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;

    // configuration bundle
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               invert;
        logic [LEVEL_W-1:0] low_level;
        logic [LEVEL_W-1:0] high_level;
        logic [COORD_W-1:0] roi_left;
        logic [COORD_W-1:0] roi_right;
        logic [COORD_W-1:0] roi_top;
        logic [COORD_W-1:0] roi_bottom;
    } cfg_t;

endpackage

`default_nettype wire

### design/rtb_cfg_regs.sv
// ---------------------------------------------------------------------------
// rtb_cfg_regs: configuration register file
// Decodes the write port into the mode, invert, level and region registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtb_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rtb_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [rtb_pkg::LEVEL_W-1:0]   cfg_data,
    output rtb_pkg::cfg_t                      cfg
);

    rtb_pkg::cfg_t cfg_reg;
    rtb_pkg::cfg_t cfg_next;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rtb_pkg::CFG_MODE:       cfg_next.mode       = cfg_data[rtb_pkg::MODE_W-1:0];
                rtb_pkg::CFG_INVERT:     cfg_next.invert     = cfg_data[0];
                rtb_pkg::CFG_LOW_LEVEL:  cfg_next.low_level  = cfg_data;
                rtb_pkg::CFG_HIGH_LEVEL: cfg_next.high_level = cfg_data;
                rtb_pkg::CFG_ROI_LEFT:   cfg_next.roi_left   = cfg_data;
                rtb_pkg::CFG_ROI_RIGHT:  cfg_next.roi_right  = cfg_data;
                rtb_pkg::CFG_ROI_TOP:    cfg_next.roi_top    = cfg_data;
                rtb_pkg::CFG_ROI_BOTTOM: cfg_next.roi_bottom = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // registers, full frame after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= rtb_pkg::MODE_BELOW;
            cfg_reg.invert     <= 1'b0;
            cfg_reg.low_level  <= '0;
            cfg_reg.high_level <= rtb_pkg::LEVEL_MAX;
            cfg_reg.roi_left   <= '0;
            cfg_reg.roi_right  <= rtb_pkg::COORD_MAX;
            cfg_reg.roi_top    <= '0;
            cfg_reg.roi_bottom <= rtb_pkg::COORD_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/rtb_profile_mem.sv
// ---------------------------------------------------------------------------
// rtb_profile_mem: per-column profile memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtb_profile_mem #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [rtb_pkg::LEVEL_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [rtb_pkg::LEVEL_W-1:0]   rd_data
);

    logic [rtb_pkg::LEVEL_W-1:0] mem [DEPTH];
    logic [rtb_pkg::LEVEL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/rtb_classify.sv
// ---------------------------------------------------------------------------
// rtb_classify: region test and threshold decision
// Tests the region, compares the scaled pixel against the fixed or profile
// relative levels and picks the target or background level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtb_classify #(
    parameter int unsigned FRAC_BITS = 4
) (
    input  wire rtb_pkg::cfg_t                 cfg,
    input  wire logic [rtb_pkg::COORD_W-1:0]   column,
    input  wire logic [rtb_pkg::COORD_W-1:0]   row,
    input  wire logic [rtb_pkg::PIX_W-1:0]     pixel,
    input  wire logic [rtb_pkg::LEVEL_W-1:0]   profile,
    output logic      [rtb_pkg::PIX_W-1:0]     out_pixel
);

    localparam int unsigned SCALED_W = rtb_pkg::PIX_W + FRAC_BITS;
    localparam int unsigned BASE_W   = (SCALED_W > rtb_pkg::LEVEL_W) ? SCALED_W
                                                                     : rtb_pkg::LEVEL_W;
    localparam int unsigned CMP_W    = BASE_W + 1;

    logic [CMP_W-1:0] p_ext;
    logic [CMP_W-1:0] lo_ext;
    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] prof_ext;
    logic [CMP_W-1:0] p_plus_lo;
    logic [CMP_W-1:0] prof_plus_hi;
    logic             in_roi;
    logic             below_fixed;
    logic             above_fixed;
    logic             below_prof;
    logic             above_prof;
    logic             hit;

    // scaled pixel and levels
    assign p_ext        = CMP_W'(pixel) << FRAC_BITS;
    assign lo_ext       = CMP_W'(cfg.low_level);
    assign hi_ext       = CMP_W'(cfg.high_level);
    assign prof_ext     = CMP_W'(profile);
    assign p_plus_lo    = p_ext + lo_ext;
    assign prof_plus_hi = prof_ext + hi_ext;

    // inclusive region test
    assign in_roi = (column >= cfg.roi_left) && (column <= cfg.roi_right) &&
                    (row >= cfg.roi_top) && (row <= cfg.roi_bottom);

    // compares; p < prof - lo is tested as p + lo < prof, no sign needed
    assign below_fixed = p_ext < lo_ext;
    assign above_fixed = p_ext > hi_ext;
    assign below_prof  = p_plus_lo < prof_ext;
    assign above_prof  = p_ext > prof_plus_hi;

    // mode select, unused modes never hit
    always_comb
    begin
        case (cfg.mode)
            rtb_pkg::MODE_BELOW:      hit = below_fixed;
            rtb_pkg::MODE_ABOVE:      hit = above_fixed;
            rtb_pkg::MODE_OUTSIDE:    hit = below_fixed || above_fixed;
            rtb_pkg::MODE_PROF_BELOW: hit = below_prof;
            rtb_pkg::MODE_PROF_ABOVE: hit = above_prof;
            rtb_pkg::MODE_PROF_OUT:   hit = below_prof || above_prof;
            default:                  hit = 1'b0;
        endcase
    end

    // target or background, swapped by invert
    always_comb
    begin
        if ((in_roi && hit) != cfg.invert)
        begin
            out_pixel = rtb_pkg::LEVEL_TARGET;
        end
        else
        begin
            out_pixel = rtb_pkg::LEVEL_BACKGROUND;
        end
    end

endmodule

`default_nettype wire

### design/roi_threshold_binarizer_unit.sv
// ---------------------------------------------------------------------------
// roi_threshold_binarizer_unit: region of interest threshold binarizer
// Binarizes a pixel stream against fixed or per-column profile levels and
// loads the profile memory from the same input stream.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | in_valid/in_stall  | cmd, column, row, pixel, profile_value
//  output   | out       | out_valid/out_stall| out_pixel
//  config   | in        | cfg_we             | cfg_index, cfg_data
//
//  one item per cycle while in_stall is low; a classify transfer gives its result
//  through the profile read register, then the output register; a load gives none
//  the profile memory read port is registered; the memory is not
//  cleared, so an entry must be loaded before a profile mode reads it
//  reset clears the control state and the configuration registers
//  an output stall holds the output register; the input stage keeps taking
//  transfers until it too is full
//
`timescale 1ns / 1ps
`default_nettype none

module roi_threshold_binarizer_unit #(
    parameter int unsigned MAX_COLUMNS = 4096,
    parameter int unsigned FRAC_BITS   = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rtb_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [rtb_pkg::LEVEL_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [rtb_pkg::COORD_W-1:0]   column,
    input  wire logic [rtb_pkg::COORD_W-1:0]   row,
    input  wire logic [rtb_pkg::PIX_W-1:0]     pixel,
    input  wire logic [rtb_pkg::LEVEL_W-1:0]   profile_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rtb_pkg::PIX_W-1:0]     out_pixel
);

    localparam int unsigned ADDR_W = $clog2(MAX_COLUMNS);
    localparam int unsigned EXT_W  = (ADDR_W > rtb_pkg::COORD_W) ? ADDR_W
                                                                 : rtb_pkg::COORD_W;

    rtb_pkg::cfg_t               cfg;
    logic [EXT_W-1:0]            column_ext;
    logic [ADDR_W-1:0]           addr;
    logic                        col_in_range;
    logic                        accept;
    logic                        out_ready;
    logic                        s1_ready;
    logic [rtb_pkg::LEVEL_W-1:0] rd_data;
    logic [rtb_pkg::LEVEL_W-1:0] profile;
    logic [rtb_pkg::PIX_W-1:0]   decided_pixel;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_in_range_reg;
    logic [rtb_pkg::COORD_W-1:0] s1_column_reg;
    logic [rtb_pkg::COORD_W-1:0] s1_row_reg;
    logic [rtb_pkg::PIX_W-1:0]   s1_pixel_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rtb_pkg::PIX_W-1:0]   out_pixel_reg;

    // configuration registers
    rtb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && s1_ready;

    // profile address and range check
    assign column_ext   = EXT_W'(column);
    assign addr         = column_ext[ADDR_W-1:0];
    assign col_in_range = {20'd0, column} < 32'(MAX_COLUMNS);

    // profile memory
    rtb_profile_mem #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_profile_mem (
        .clk     (clk),
        .wr_en   (accept && (cmd == rtb_pkg::CMD_LOAD) && col_in_range),
        .wr_addr (addr),
        .wr_data (profile_value),
        .rd_en   (accept && (cmd == rtb_pkg::CMD_CLASSIFY)),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // input stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = accept && (cmd == rtb_pkg::CMD_CLASSIFY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept && (cmd == rtb_pkg::CMD_CLASSIFY))
        begin
            s1_in_range_reg <= col_in_range;
            s1_column_reg   <= column;
            s1_row_reg      <= row;
            s1_pixel_reg    <= pixel;
        end
    end

    // columns beyond the memory use a zero profile
    assign profile = s1_in_range_reg ? rd_data : '0;

    // decision
    rtb_classify #(
        .FRAC_BITS (FRAC_BITS)
    ) u_classify (
        .cfg       (cfg),
        .column    (s1_column_reg),
        .row       (s1_row_reg),
        .pixel     (s1_pixel_reg),
        .profile   (profile),
        .out_pixel (decided_pixel)
    );

    // output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_pixel_reg <= decided_pixel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

`default_nettype wire
